// ===== hdl/wes_pkg.sv =====
package wes_pkg;

  // Sizes fixed by the item formats
  localparam int CELLS_DEFAULT = 1024;
  localparam int ACTIVE_W      = 11;
  localparam int ACTIVE_MIN    = 3;
  localparam int INDEX_W       = 10;
  localparam int COEF_W        = 17;
  localparam int DISP_W        = 32;
  localparam int POS_MAX_W     = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;
  localparam logic [COEF_W-1:0]   BETA_ONE     = 17'd65536;

  // Opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic [INDEX_W-1:0]       coefficient_index;
    logic [COEF_W-1:0]        coefficient_value;
    logic signed [DISP_W-1:0] left_boundary_value;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]       cell_index;
    logic signed [DISP_W-1:0] new_displacement;
    logic                     sweep_done;
    logic                     stability_error;
  } out_item_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic                     is_update;
    logic [POS_MAX_W-1:0]     pos;
    logic                     first;
    logic                     last;
    logic                     cur_bank;
    logic                     load_en;
    logic [COEF_W-1:0]        coef;
    logic signed [DISP_W-1:0] boundary;
  } cmd_t;

endpackage

// ===== hdl/wave_equation_stencil_step.sv =====
// channel  dir  handshake              payload
// in_      in   in_valid / in_ready    wes_pkg::in_item_t (load coefficient or update cell)
// out_     out  out_valid / out_ready  wes_pkg::out_item_t (one per update, none per load)
// cfg_     in   cfg_valid / cfg_ready  active_cells, 11 bits, always ready
//
// Sustains one transaction per cycle on both channels unless a full queue, clearing,
// a held out_ready or a hazard stalls it. An update passes queue slot, memory read,
// operand, product, sum and round. Reset is synchronous; afterwards a clearing pass
// zeroes all (CELLS+1)/2 rows of every memory, one row per cycle, with in_ready low
// and configuration still taken. A held out_ready freezes the back pipeline; the
// four-entry queue keeps in_ready high until it fills. An update whose cells the
// previous sweep is still writing back waits, which only shows on very short sweeps.
module wave_equation_stencil_step #(
  parameter int CELLS = wes_pkg::CELLS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  wes_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output wes_pkg::out_item_t           out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wes_pkg::ACTIVE_W-1:0] cfg_data
);

  import wes_pkg::*;

  // Front to queue
  logic push;
  cmd_t push_cmd;

  // Queue to back
  cmd_t q_head;
  logic q_valid;
  logic q_full;
  logic q_pop;

  // Back holds the front off while the memories are being cleared
  logic clearing;

  // Front: take transactions, track the sweep position and the bank roles, and
  // turn each item into a command with its boundary flags already resolved.
  wes_front #(
    .CELLS(CELLS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple the two halves so that each can stall on its own
  wes_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .not_empty(q_valid),
    .full     (q_full)
  );

  // Back: read the stencil from the parity-split banks, run the arithmetic
  // pipeline, write the new cell and drive the output register.
  wes_back #(
    .CELLS(CELLS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

// ===== hdl/wes_ram.sv =====
module wes_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [WIDTH-1:0]  rd_a_r,
  output logic [WIDTH-1:0]  rd_b_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem_r[rd_addr_a];
      rd_b_r <= mem_r[rd_addr_b];
    end
  end

endmodule

// ===== hdl/wes_queue.sv =====
module wes_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wes_pkg::cmd_t push_cmd,
  input  logic          pop,
  output wes_pkg::cmd_t head,
  output logic          not_empty,
  output logic          full
);

  import wes_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic [PTR_W:0]   count_nxt;

  assign head      = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == (PTR_W + 1)'(QUEUE_DEPTH));
  assign count_nxt = count_r + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/wes_front.sv =====
module wes_front #(
  parameter int CELLS = wes_pkg::CELLS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  wes_pkg::in_item_t            in_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wes_pkg::ACTIVE_W-1:0] cfg_data,
  input  logic                         clearing,
  input  logic                         q_full,
  output logic                         push,
  output wes_pkg::cmd_t                push_cmd
);

  import wes_pkg::*;

  localparam int PW = $clog2(CELLS);
  localparam int CW = (PW + 1 > ACTIVE_W) ? PW + 1 : ACTIVE_W;

  logic [ACTIVE_W-1:0] active_cells_r;
  logic [PW-1:0]       sweep_pos_r;
  logic [PW-1:0]       sweep_pos_nxt;
  logic                bank_sel_r;
  logic                bank_sel_nxt;
  logic [CW-1:0]       act_w;
  logic [CW-1:0]       n_w;
  logic [PW:0]         n;
  logic [PW-1:0]       pos_eff;
  logic [PW:0]         pos_plus;
  logic                accept;
  logic                is_update;
  logic                last;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full && !clearing;
  assign accept    = in_valid && in_ready;
  assign is_update = (in_item.opcode == OP_UPDATE);
  assign push      = accept;

  // Clamp the active count to [3, CELLS]
  always_comb begin
    act_w = CW'(active_cells_r);
    if (act_w < CW'(ACTIVE_MIN)) begin
      n_w = CW'(ACTIVE_MIN);
    end else if (act_w > CW'(CELLS)) begin
      n_w = CW'(CELLS);
    end else begin
      n_w = act_w;
    end
  end

  assign n        = n_w[PW:0];
  assign pos_eff  = ({1'b0, sweep_pos_r} >= n) ? '0 : sweep_pos_r;
  assign pos_plus = {1'b0, pos_eff} + (PW + 1)'(1);
  assign last     = (pos_plus >= n);

  always_comb begin
    push_cmd           = '0;
    push_cmd.is_update = is_update;
    push_cmd.coef      = in_item.coefficient_value;
    push_cmd.boundary  = in_item.left_boundary_value;
    push_cmd.cur_bank  = bank_sel_r;
    if (is_update) begin
      push_cmd.pos   = POS_MAX_W'(pos_eff);
      push_cmd.first = (pos_eff == '0);
      push_cmd.last  = last;
    end else begin
      push_cmd.pos     = POS_MAX_W'(in_item.coefficient_index);
      push_cmd.load_en = (32'(in_item.coefficient_index) < 32'(CELLS));
    end
  end

  always_comb begin
    sweep_pos_nxt = sweep_pos_r;
    bank_sel_nxt  = bank_sel_r;
    if (accept && is_update) begin
      if (last) begin
        sweep_pos_nxt = '0;
        bank_sel_nxt  = !bank_sel_r;
      end else begin
        sweep_pos_nxt = pos_plus[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_cells_r <= ACTIVE_RESET;
      sweep_pos_r    <= '0;
      bank_sel_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_cells_r <= cfg_data;
      end
      sweep_pos_r <= sweep_pos_nxt;
      bank_sel_r  <= bank_sel_nxt;
    end
  end

endmodule

// ===== hdl/wes_back.sv =====
module wes_back #(
  parameter int CELLS = wes_pkg::CELLS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  wes_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output wes_pkg::out_item_t out_item
);

  import wes_pkg::*;

  localparam int PW         = $clog2(CELLS);
  localparam int AW         = PW - 1;
  localparam int HALF       = (CELLS + 1) / 2;
  localparam int SUM_W      = 56;
  localparam int FRAC_SHIFT = 18;
  localparam int Q_W        = SUM_W - FRAC_SHIFT;
  localparam int NSTAGE     = 4;

  localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [DISP_W-1:0] DISP_MAX   = {1'b0, {(DISP_W - 1){1'b1}}};
  localparam logic signed [DISP_W-1:0] DISP_MIN   = {1'b1, {(DISP_W - 1){1'b0}}};

  typedef struct packed {
    logic          upd;
    logic [PW-1:0] pos;
    logic          wb;
    logic          last;
    logic          err;
  } meta_t;

  // Clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // Issue
  logic          adv;
  logic          issue;
  logic          hazard;
  logic [NSTAGE-1:0] hit;
  logic [PW-1:0] head_pos;
  logic [PW-1:0] pos_m1;
  logic [PW-1:0] pos_p1;
  logic          head_par;

  // Stage tags, index 0 is the stage holding the read data
  logic [NSTAGE-1:0] vld_r;
  meta_t             meta_r [NSTAGE];

  // Memory ports
  logic [DISP_W-1:0] wave_rd_a [2][2];
  logic [DISP_W-1:0] wave_rd_b [2][2];
  logic [COEF_W-1:0] coef_rd_a [2];
  logic [COEF_W-1:0] coef_rd_b [2];
  logic [3:0]        wave_we;
  logic              wr_cell;

  // Stage 1
  cmd_t                      s1_cmd_r;
  logic                      s1_cb;
  logic                      s1_par;
  logic signed [DISP_W-1:0]  f1;
  logic signed [DISP_W-1:0]  o1;
  logic signed [DISP_W-1:0]  w1;
  logic signed [DISP_W-1:0]  e1;
  logic [COEF_W-1:0]         b1;
  logic [COEF_W-1:0]         bm1;
  logic [COEF_W-1:0]         bp1;
  logic                      err1;
  meta_t                     meta1_nxt;

  // Stage 2
  logic signed [DISP_W-1:0]  s2_f_r;
  logic signed [DISP_W-1:0]  s2_o_r;
  logic [COEF_W-1:0]         s2_k_r;
  logic [COEF_W-1:0]         s2_b_r;
  logic signed [DISP_W:0]    s2_sum_r;
  logic signed [DISP_W:0]    s2_dif_r;
  logic signed [COEF_W:0]    s2_db_r;
  logic signed [COEF_W+DISP_W:0]   p1;
  logic signed [COEF_W+DISP_W+1:0] p2;
  logic signed [COEF_W+DISP_W+1:0] p3;

  // Stage 3
  logic signed [COEF_W+DISP_W:0]   s3_p1_r;
  logic signed [COEF_W+DISP_W+1:0] s3_p2_r;
  logic signed [COEF_W+DISP_W+1:0] s3_p3_r;
  logic signed [DISP_W-1:0]        s3_o_r;
  logic signed [SUM_W-1:0]         sum3;

  // Stage 4
  logic signed [SUM_W-1:0]   s4_sum_r;
  logic signed [SUM_W-1:0]   rnd4;
  logic [Q_W-1:0]            q4;
  logic signed [DISP_W-1:0]  sat4;
  logic signed [DISP_W-1:0]  result4;

  // Output register
  logic      out_valid_r;
  out_item_t out_item_r;

  assign adv       = !out_valid_r || out_ready;
  assign clearing  = clr_busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign head_pos = q_head.pos[PW-1:0];
  assign head_par = head_pos[0];
  assign pos_m1   = head_pos - 1'b1;
  assign pos_p1   = head_pos + 1'b1;

  // Hold an update while a cell it reads is still on its way to memory; the west
  // neighbour of the first cell and the east neighbour of the last are not read
  always_comb begin
    for (int k = 0; k < NSTAGE; k++) begin
      hit[k] = vld_r[k] && meta_r[k].upd &&
               (((meta_r[k].wb == q_head.cur_bank) &&
                 ((!q_head.first && (meta_r[k].pos == pos_m1)) ||
                  (meta_r[k].pos == head_pos) ||
                  (!q_head.last && (meta_r[k].pos == pos_p1)))) ||
                ((meta_r[k].wb != q_head.cur_bank) && (meta_r[k].pos == head_pos)));
    end
  end

  assign hazard = q_head.is_update && (|hit);
  assign issue  = q_valid && !clr_busy_r && adv && !hazard;
  assign q_pop  = issue;

  assign wr_cell = adv && vld_r[NSTAGE-1] && meta_r[NSTAGE-1].upd && !meta_r[NSTAGE-1].err;

  // Displacement banks, split by cell parity so that west and east share one memory
  for (genvar gb = 0; gb < 2; gb++) begin : g_bank
    for (genvar gp = 0; gp < 2; gp++) begin : g_par
      logic          is_cur;
      logic          same_par;
      logic [AW-1:0] rd_addr_a;
      logic          we;
      logic [AW-1:0] wr_addr;
      logic [DISP_W-1:0] wr_data;

      assign is_cur    = (q_head.cur_bank == 1'(gb));
      assign same_par  = (head_par == 1'(gp));
      assign rd_addr_a = (is_cur && !same_par) ? pos_m1[PW-1:1] : head_pos[PW-1:1];
      assign wave_we[gb*2+gp] = wr_cell && (meta_r[NSTAGE-1].wb == 1'(gb)) &&
                                (meta_r[NSTAGE-1].pos[0] == 1'(gp));
      assign we      = clr_busy_r || wave_we[gb*2+gp];
      assign wr_addr = clr_busy_r ? clr_addr_r : meta_r[NSTAGE-1].pos[PW-1:1];
      assign wr_data = clr_busy_r ? '0 : result4;

      wes_ram #(
        .WIDTH (DISP_W),
        .DEPTH (HALF),
        .ADDR_W(AW)
      ) u_wave (
        .clk      (clk),
        .wr_en    (we),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (adv),
        .rd_addr_a(rd_addr_a),
        .rd_addr_b(pos_p1[PW-1:1]),
        .rd_a_r   (wave_rd_a[gb][gp]),
        .rd_b_r   (wave_rd_b[gb][gp])
      );
    end
  end

  // Coefficient table, same parity split
  for (genvar gp = 0; gp < 2; gp++) begin : g_coef
    logic          same_par;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [COEF_W-1:0] wr_data;

    assign same_par = (head_par == 1'(gp));
    assign we       = clr_busy_r ||
                      (issue && !q_head.is_update && q_head.load_en &&
                       (q_head.pos[0] == 1'(gp)));
    assign wr_addr  = clr_busy_r ? clr_addr_r : q_head.pos[PW-1:1];
    assign wr_data  = clr_busy_r ? '0 : q_head.coef;

    wes_ram #(
      .WIDTH (COEF_W),
      .DEPTH (HALF),
      .ADDR_W(AW)
    ) u_coef (
      .clk      (clk),
      .wr_en    (we),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (adv),
      .rd_addr_a(same_par ? head_pos[PW-1:1] : pos_m1[PW-1:1]),
      .rd_addr_b(pos_p1[PW-1:1]),
      .rd_a_r   (coef_rd_a[gp]),
      .rd_b_r   (coef_rd_b[gp])
    );
  end

  // Stage 1: pick the neighbours, apply the boundaries, form sums
  assign s1_cb  = s1_cmd_r.cur_bank;
  assign s1_par = s1_cmd_r.pos[0];

  always_comb begin
    f1   = wave_rd_a[s1_cb][s1_par];
    o1   = wave_rd_a[~s1_cb][s1_par];
    w1   = s1_cmd_r.first ? s1_cmd_r.boundary : wave_rd_a[s1_cb][~s1_par];
    e1   = s1_cmd_r.last ? f1 : wave_rd_b[s1_cb][~s1_par];
    b1   = coef_rd_a[s1_par];
    bm1  = s1_cmd_r.first ? '0 : coef_rd_a[~s1_par];
    bp1  = s1_cmd_r.last ? '0 : coef_rd_b[~s1_par];
    err1 = (b1 > BETA_ONE);
    meta1_nxt     = meta_r[0];
    meta1_nxt.err = err1;
  end

  // Stage 2: three products
  assign p1 = $signed({1'b0, s2_k_r}) * s2_f_r;
  assign p2 = $signed({1'b0, s2_b_r}) * s2_sum_r;
  assign p3 = s2_db_r * s2_dif_r;

  // Stage 3: sum at Q38.18 scale
  assign sum3 = (SUM_W'(s3_p1_r) <<< 3) + (SUM_W'(s3_p2_r) <<< 2) + SUM_W'(s3_p3_r)
              - (SUM_W'(s3_o_r) <<< FRAC_SHIFT);

  // Stage 4: round half up, saturate, force zero on a stability error
  always_comb begin
    rnd4 = s4_sum_r + ROUND_HALF;
    q4   = rnd4[SUM_W-1:FRAC_SHIFT];
    if ((&q4[Q_W-1:DISP_W-1]) || !(|q4[Q_W-1:DISP_W-1])) begin
      sat4 = q4[DISP_W-1:0];
    end else if (q4[Q_W-1]) begin
      sat4 = DISP_MIN;
    end else begin
      sat4 = DISP_MAX;
    end
    result4 = meta_r[NSTAGE-1].err ? '0 : sat4;
  end

  // Datapath registers, advance together
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r <= q_head;

      meta_r[0].upd  <= q_head.is_update;
      meta_r[0].pos  <= head_pos;
      meta_r[0].wb   <= !q_head.cur_bank;
      meta_r[0].last <= q_head.last;
      meta_r[0].err  <= 1'b0;

      meta_r[1] <= meta1_nxt;
      meta_r[2] <= meta_r[1];
      meta_r[3] <= meta_r[2];

      s2_f_r   <= f1;
      s2_o_r   <= o1;
      s2_k_r   <= BETA_ONE - b1;
      s2_b_r   <= b1;
      s2_sum_r <= (DISP_W + 1)'(e1) + (DISP_W + 1)'(w1);
      s2_dif_r <= (DISP_W + 1)'(e1) - (DISP_W + 1)'(w1);
      s2_db_r  <= $signed({1'b0, bp1}) - $signed({1'b0, bm1});

      s3_p1_r <= p1;
      s3_p2_r <= p2;
      s3_p3_r <= p3;
      s3_o_r  <= s2_o_r;

      s4_sum_r <= sum3;

      out_item_r.cell_index       <= INDEX_W'(meta_r[NSTAGE-1].pos);
      out_item_r.new_displacement <= result4;
      out_item_r.sweep_done       <= meta_r[NSTAGE-1].last;
      out_item_r.stability_error  <= meta_r[NSTAGE-1].err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
    end else begin
      if (adv) begin
        vld_r       <= {vld_r[NSTAGE-2:0], issue};
        out_valid_r <= vld_r[NSTAGE-1] && meta_r[NSTAGE-1].upd;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(HALF - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !q_pop)
    else $error("command issued during clearing pass");

  a_single_cell_write: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |-> $onehot0(wave_we))
    else $error("more than one displacement memory written");

  a_stall_holds_write: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> (wave_we == '0))
    else $error("cell written while the pipeline is held");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.stability_error) |-> (out_item_r.new_displacement == '0))
    else $error("stability error with non-zero displacement");

  a_clear_length: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> ($past(clr_addr_r) == AW'(HALF - 1)))
    else $error("clearing pass ended early");

endmodule
